FILE: src/lsbex_pkg.sv
// Package for the LSB audio steganography extractor.
// Holds the register map, field widths, default parameters and the RIFF signature.
// No dependencies.
`timescale 1ns / 1ps

package lsbex_pkg;

  // Field and register widths
  localparam int FILE_SIZE_W = 32;
  localparam int MAX_LEN_W   = 28;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  // Default values for the top-level parameters
  localparam int HEADER_BYTES_DEF = 44;
  localparam int LENGTH_BITS_DEF  = 32;

  // Register reset value
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(100000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 1'b1;

  // Result status codes
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // Expected character at each of the first four file bytes ("RIFF").
  function automatic logic [7:0] riff_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h52;
      2'd1:    c = 8'h49;
      2'd2:    c = 8'h46;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

FILE: src/lsb_audio_stego_extract.sv
// An accepted input item is held in the input register; any result it yields is registered on the master side.
// Throughput: one item per cycle; the slave side stalls only while a result waits
// on the master side and the input register is also full.
// Reset (rst, synchronous): parser back to header phase at byte 0, output empty,
// file_size cleared and max_message_length set to 100000.
// Top level of the LSB audio steganography extractor.
// Depends on lsbex_pkg.
`timescale 1ns / 1ps

module lsb_audio_stego_extract
  import lsbex_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input item stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tuser,   // [0] file_start
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] message_byte
  output logic                  m_axis_tuser,   // [0] status
  output logic                  m_axis_tlast,   // last_of_message
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PREFIX_END = HEADER_BYTES + LENGTH_BITS;
  localparam int POS_W      = $clog2(PREFIX_END);
  localparam int ROOM_W     = FILE_SIZE_W + 1;

  // Parser phases
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_LENGTH  = 2'd1;
  localparam logic [1:0] MODE_MESSAGE = 2'd2;
  localparam logic [1:0] MODE_DONE    = 2'd3;

  // Configuration registers
  logic [FILE_SIZE_W-1:0] file_size;
  logic [MAX_LEN_W-1:0]   max_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
      max_len   <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILE_SIZE: file_size <= cfg_data;
        REG_MAX_LEN:   max_len   <= cfg_data[MAX_LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;

  logic       out_valid;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  // Parser state. In the message phase pos counts bits within a byte and
  // len_acc holds the number of message bytes still to come after the current one.
  logic [1:0]             mode, mode_next;
  logic [POS_W-1:0]       pos, pos_next;
  logic [LENGTH_BITS-1:0] len_acc, len_acc_next;
  logic [6:0]             bit_acc, bit_acc_next;

  // State as seen by the current item, after a possible file restart
  logic [1:0]             st_mode;
  logic [POS_W-1:0]       st_pos;
  logic [LENGTH_BITS-1:0] st_len;
  logic [6:0]             st_bits;

  logic                   res_valid;
  logic [7:0]             res_byte;
  logic                   res_status;
  logic                   res_last;

  logic                   in_bit;
  logic [LENGTH_BITS-1:0] len_new;
  logic                   len_bad;
  logic [ROOM_W-1:0]      room;
  logic [ROOM_W-1:0]      need;
  logic                   room_bad;
  logic                   too_small;

  assign in_bit  = in_byte[0];
  assign len_new = {st_len[LENGTH_BITS-2:0], in_bit};

  // Length prefix checks
  assign len_bad   = (len_new == '0) ||
                     (ROOM_W'(len_new) > ROOM_W'(max_len));
  assign room      = ROOM_W'(file_size) - ROOM_W'(HEADER_BYTES);
  assign need      = ROOM_W'(LENGTH_BITS) + (ROOM_W'(len_new) << 3);
  assign room_bad  = (file_size >= FILE_SIZE_W'(HEADER_BYTES)) && (room < need);
  assign too_small = file_size < FILE_SIZE_W'(PREFIX_END);

  always_comb begin
    st_mode = in_start ? MODE_HEADER : mode;
    st_pos  = in_start ? '0 : pos;
    st_len  = in_start ? '0 : len_acc;
    st_bits = in_start ? '0 : bit_acc;

    mode_next    = st_mode;
    pos_next     = st_pos;
    len_acc_next = st_len;
    bit_acc_next = st_bits;
    res_valid    = 1'b0;
    res_byte     = '0;
    res_status   = STATUS_DATA;
    res_last     = 1'b0;

    unique case (st_mode)
      // Header: size and signature checks, then skip to the prefix
      MODE_HEADER: begin
        if ((st_pos == '0 && too_small) ||
            (st_pos < POS_W'(4) && in_byte != riff_char(st_pos[1:0]))) begin
          res_valid  = 1'b1;
          res_status = STATUS_ERROR;
          res_last   = 1'b1;
          mode_next  = MODE_DONE;
        end else begin
          pos_next = st_pos + 1'b1;
          if (st_pos == POS_W'(HEADER_BYTES - 1)) begin
            mode_next    = MODE_LENGTH;
            len_acc_next = '0;
          end
        end
      end
      // Length prefix, most significant bit first
      MODE_LENGTH: begin
        if (st_pos == POS_W'(PREFIX_END - 1)) begin
          if (len_bad || room_bad) begin
            res_valid  = 1'b1;
            res_status = STATUS_ERROR;
            res_last   = 1'b1;
            mode_next  = MODE_DONE;
          end else begin
            mode_next    = MODE_MESSAGE;
            pos_next     = '0;
            bit_acc_next = '0;
            len_acc_next = len_new - 1'b1;
          end
        end else begin
          pos_next     = st_pos + 1'b1;
          len_acc_next = len_new;
        end
      end
      // Message: eight low bits make one byte
      MODE_MESSAGE: begin
        if (st_pos[2:0] == 3'd7) begin
          res_valid    = 1'b1;
          res_byte     = {st_bits, in_bit};
          bit_acc_next = '0;
          pos_next     = '0;
          if (st_len == '0) begin
            res_last  = 1'b1;
            mode_next = MODE_DONE;
          end else begin
            len_acc_next = st_len - 1'b1;
          end
        end else begin
          bit_acc_next = {st_bits[5:0], in_bit};
          pos_next     = st_pos + 1'b1;
        end
      end
      default: begin
        // Done: bytes are ignored until the next file start
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_HEADER;
      pos     <= '0;
      len_acc <= '0;
      bit_acc <= '0;
    end else if (advance) begin
      mode    <= mode_next;
      pos     <= pos_next;
      len_acc <= len_acc_next;
      bit_acc <= bit_acc_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= res_status;
      m_axis_tlast <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;

endmodule

FILE: src/lsbex_checker.sv
// Port-level checks for the LSB audio steganography extractor, bound to the top level.
// Depends on lsbex_pkg and lsb_audio_stego_extract.
`timescale 1ns / 1ps

module lsbex_checker
  import lsbex_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [7:0]            m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // An error result carries a zero byte and closes the message.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STATUS_ERROR |->
      m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("malformed error result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered right after reset");

endmodule

bind lsb_audio_stego_extract lsbex_checker u_lsbex_checker (.*);

FILE: test/lsb_audio_stego_extract_test.sv
// Testbench for lsb_audio_stego_extract: streams WAV byte images and checks each
// extracted message byte or error result against a predictor built into this file.
// Depends on lsbex_pkg and the lsb_audio_stego_extract RTL.
`timescale 1ns / 1ps

module lsb_audio_stego_extract_test;
  import lsbex_pkg::*;

  localparam int HDR           = HEADER_BYTES_DEF;
  localparam int PREFIX        = LENGTH_BITS_DEF;
  localparam int PAYLOAD_START = HDR + PREFIX;
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;  // "RIFF", first byte lowest
  localparam int LIMIT_NS      = 4_000_000;
  localparam int ITEMS_TARGET  = 750;
  localparam int MIN_RANDOM_FILES = 6;

  typedef enum logic [1:0] {
    PHASE_HEADER,
    PHASE_LENGTH,
    PHASE_MESSAGE,
    PHASE_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       status;
    logic       last_byte;
  } extract_result_t;

  typedef logic [7:0] wav_bytes_t[$];

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic                  s_axis_tuser = 1'b0;   // [0] file_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;          // [7:0] message_byte
  logic                  m_axis_tuser;          // [0] status
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FILE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the parser state.
  logic [31:0]  cfg_file_size = 32'd0;
  logic [27:0]  cfg_max_len = MAX_LEN_RESET;
  logic [31:0]  byte_pos = 32'd0;
  logic [31:0]  length_acc = 32'd0;
  logic [6:0]   bits_acc = 7'd0;
  logic [27:0]  emitted = 28'd0;
  parse_phase_t phase = PHASE_HEADER;

  extract_result_t pending_results[$];
  int items_sent = 0;
  int failures = 0;
  bit steady_flow = 1'b0;

  lsb_audio_stego_extract dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic st, input logic lst);
    extract_result_t r;
    r.message_byte = b;
    r.status = st;
    r.last_byte = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void flag_bad_file();
    push_result(8'h00, STATUS_ERROR, 1'b1);
    phase = PHASE_DONE;
  endfunction

  // Advance the parser by one accepted byte and queue any result it yields.
  function automatic void predict_extract(input logic start, input logic [7:0] b);
    logic [31:0] p;
    logic [31:0] k;
    longint unsigned room;
    if (start) begin
      byte_pos = 32'd0;
      length_acc = 32'd0;
      bits_acc = 7'd0;
      emitted = 28'd0;
      phase = PHASE_HEADER;
    end
    if (phase == PHASE_DONE) return;
    p = byte_pos;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
    case (phase)
      PHASE_HEADER: begin
        if (p == 0 && cfg_file_size < PAYLOAD_START) flag_bad_file();
        else if (p < 4 && b != RIFF_TAG[8*p[1:0] +: 8]) flag_bad_file();
        else if (p + 32'd1 >= HDR) begin
          phase = PHASE_LENGTH;
          length_acc = 32'd0;
        end
      end
      PHASE_LENGTH: begin
        length_acc = {length_acc[30:0], b[0]};
        if (p + 32'd1 >= PAYLOAD_START) begin
          room = 64'(cfg_file_size) - 64'(HDR);
          if (length_acc == 0 || length_acc > cfg_max_len) flag_bad_file();
          else if (room < 64'(PREFIX) + 64'(length_acc) * 64'd8) flag_bad_file();
          else begin
            phase = PHASE_MESSAGE;
            bits_acc = 7'd0;
            emitted = 28'd0;
          end
        end
      end
      default: begin
        k = p - 32'(PAYLOAD_START);
        if (k[2:0] != 3'd7) begin
          bits_acc = {bits_acc[5:0], b[0]};
        end else begin
          emitted = emitted + 28'd1;
          if ({4'b0, emitted} >= length_acc) begin
            push_result({bits_acc, b[0]}, STATUS_DATA, 1'b1);
            phase = PHASE_DONE;
          end else begin
            push_result({bits_acc, b[0]}, STATUS_DATA, 1'b0);
          end
          bits_acc = 7'd0;
        end
      end
    endcase
  endfunction

  // Predict on every accepted input item, then check every accepted result.
  always @(posedge clk) begin : result_check
    extract_result_t seen;
    extract_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_extract(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result byte %02h status %0d last %0d",
                                   seen.message_byte, seen.status, seen.last_byte));
        end else begin
          want = pending_results.pop_front();
          if (seen.message_byte !== want.message_byte || seen.status !== want.status ||
              seen.last_byte !== want.last_byte) begin
            report_failure($sformatf(
              "expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
              want.message_byte, want.status, want.last_byte,
              seen.message_byte, seen.status, seen.last_byte));
          end
        end
      end
    end
  end

  // Result side back-pressure.
  initial begin : result_drain
    int stall;
    forever begin
      @(negedge clk);
      stall = (steady_flow || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_item(input logic start, input logic [7:0] b);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Hold the input side until every queued result has come and the pipe is empty.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FILE_SIZE) cfg_file_size = val;
    else cfg_max_len = val[27:0];
  endtask

  // Build a file image: signature, random header, length prefix in the low bits,
  // then body_len random bytes.
  function automatic wav_bytes_t wav_image(input logic [31:0] length_field, input int body_len);
    wav_bytes_t f;
    logic [7:0] b;
    f = {};
    for (int i = 0; i < PAYLOAD_START + body_len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i < 4) b = RIFF_TAG[8*i +: 8];
      else if (i >= HDR && i < PAYLOAD_START) b[0] = length_field[PAYLOAD_START - 1 - i];
      f.insert(f.size(), b);
    end
    return f;
  endfunction

  // Send the first count bytes of an image; only the first may carry the start flag.
  task automatic send_bytes(input wav_bytes_t f, input logic start, input int count);
    for (int i = 0; i < count && i < f.size(); i++) send_item(i == 0 ? start : 1'b0, f[i]);
  endtask

  // Right after reset, with the default length limit and no start flag.
  task automatic test_reset_defaults();
    wav_bytes_t f;
    write_reg(REG_FILE_SIZE, 32'(PAYLOAD_START + 16));
    f = wav_image(32'd2, 16 + 3);
    send_bytes(f, 1'b0, f.size());
  endtask

  // Files below header plus prefix fail on their first byte.
  task automatic test_small_file();
    wav_bytes_t f;
    f = wav_image(32'd1, 8);
    write_reg(REG_FILE_SIZE, 32'd0);
    send_bytes(f, 1'b1, 5);
    write_reg(REG_FILE_SIZE, 32'(PAYLOAD_START - 1));
    send_bytes(f, 1'b1, 3);
  endtask

  // A wrong signature byte at each of the four positions.
  task automatic test_signature();
    wav_bytes_t f;
    write_reg(REG_FILE_SIZE, 32'hFFFF_FFFF);
    for (int k = 0; k < 4; k++) begin
      f = wav_image(32'd1, 8);
      f[k] = (k % 2 == 0) ? 8'h00 : 8'hFF;
      send_bytes(f, 1'b1, k + 3);
    end
  endtask

  // Length prefix checks: zero, over the limit, top bit set, room boundary,
  // and a limit change in the middle of a file.
  task automatic test_length_prefix();
    wav_bytes_t f;
    write_reg(REG_FILE_SIZE, 32'd200);
    f = wav_image(32'd0, 4);
    send_bytes(f, 1'b1, f.size());
    write_reg(REG_MAX_LEN, 32'd3);
    f = wav_image(32'd4, 32);
    send_bytes(f, 1'b1, f.size());
    f = wav_image(32'd3, 24);
    send_bytes(f, 1'b1, f.size());
    f = wav_image(32'h8000_0001, 2);
    send_bytes(f, 1'b1, f.size());
    write_reg(REG_FILE_SIZE, 32'(PAYLOAD_START + 24 - 1));
    f = wav_image(32'd3, 24);
    send_bytes(f, 1'b1, f.size());
    write_reg(REG_FILE_SIZE, 32'(PAYLOAD_START + 24));
    f = wav_image(32'd3, 24);
    send_bytes(f, 1'b1, f.size());
    f = wav_image(32'd2, 16);
    send_bytes(f, 1'b1, 60);
    write_reg(REG_MAX_LEN, 32'd1);
    for (int i = 60; i < f.size(); i++) send_item(1'b0, f[i]);
  endtask

  // Restart in the middle of a message, then trailing bytes after a message.
  task automatic test_restart_and_tail();
    wav_bytes_t f;
    write_reg(REG_MAX_LEN, 32'(MAX_LEN_RESET));
    write_reg(REG_FILE_SIZE, 32'd500);
    f = wav_image(32'd4, 32);
    send_bytes(f, 1'b1, PAYLOAD_START + 13);
    f = wav_image(32'd1, 8 + 5);
    send_bytes(f, 1'b1, f.size());
  endtask

  // Largest register values, a length of zero limit, and a huge accepted length.
  task automatic test_register_extremes();
    wav_bytes_t f;
    write_reg(REG_MAX_LEN, 32'd0);
    f = wav_image(32'd1, 8);
    send_bytes(f, 1'b1, f.size());
    write_reg(REG_MAX_LEN, 32'hFFFF_FFFF);
    write_reg(REG_FILE_SIZE, 32'hFFFF_FFFF);
    f = wav_image(32'h0FFF_FFFF, 24);
    send_bytes(f, 1'b1, f.size());
    f = wav_image(32'h1000_0000, 2);
    send_bytes(f, 1'b1, f.size());
  endtask

  // Mostly well-formed files with random content, mixed with broken ones and noise.
  // A few files always go out; after that the run stops once its item budget is spent.
  task automatic test_random_files();
    wav_bytes_t f;
    int files;
    int r;
    int len;
    int fit;
    int pos;
    files = 0;
    while (files < MIN_RANDOM_FILES || items_sent < ITEMS_TARGET) begin
      files++;
      steady_flow = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      fit = PAYLOAD_START + 8 * len;
      if (r < 75) begin
        // Good file, or a truncated one that the next start flag cuts off.
        if ($urandom_range(0, 11) == 0) write_reg(REG_MAX_LEN, 32'($urandom_range(1, 8)));
        else if (cfg_max_len < len && $urandom_range(0, 3) != 0)
          write_reg(REG_MAX_LEN, 32'(len + $urandom_range(0, 20)));
        if (cfg_file_size < fit || $urandom_range(0, 2) == 0)
          write_reg(REG_FILE_SIZE,
                    32'(fit + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40))));
        f = wav_image(32'(len), 8 * len + $urandom_range(0, 4));
        if (r < 65) send_bytes(f, 1'b1, f.size());
        else send_bytes(f, 1'b1, $urandom_range(1, f.size() - 1));
      end else if (r < 82) begin
        // Broken signature.
        pos = $urandom_range(0, 3);
        f = wav_image(32'(len), 8);
        f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
        send_bytes(f, 1'b1, $urandom_range(pos + 1, 20));
      end else if (r < 90) begin
        // Length out of range.
        case ($urandom_range(0, 2))
          0: f = wav_image(32'd0, 10);
          1: f = wav_image(32'(cfg_max_len) + 32'd1, 10);
          default: f = wav_image($urandom, 10);
        endcase
        send_bytes(f, 1'b1, PAYLOAD_START + $urandom_range(0, 10));
      end else if (r < 95) begin
        // Not enough room for the message.
        write_reg(REG_FILE_SIZE, 32'(fit - $urandom_range(1, 8)));
        f = wav_image(32'(len), 8 * len);
        send_bytes(f, 1'b1, PAYLOAD_START + 4);
      end else begin
        // Noise with stray start flags.
        for (int i = 0; i < 30; i++)
          send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : run_sequence
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_small_file();
    test_signature();
    test_length_prefix();
    test_restart_and_tail();
    test_register_extremes();
    test_random_files();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 2000 && pending_results.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    while (pending_results.size() != 0) begin
      report_failure("result never arrived");
      void'(pending_results.pop_front());
    end
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/lsbex_pkg.sv
src/lsb_audio_stego_extract.sv
src/lsbex_checker.sv
test/lsb_audio_stego_extract_test.sv
